// ----- hw/rtl/tmbq_pkg.sv -----
// ----------------------------------------------------------------------------
// tmbq_pkg
// Shared sizes, codes and types for the timed message byte queue.
// ----------------------------------------------------------------------------
package tmbq_pkg;

  // Both capacities are powers of two, so the ring pointers wrap by width.
  localparam int BYTE_CAPACITY   = 64;
  localparam int RECORD_CAPACITY = 16;

  localparam int BYTE_AW = $clog2(BYTE_CAPACITY);
  localparam int REC_AW  = $clog2(RECORD_CAPACITY);
  localparam int BCNT_W  = $clog2(BYTE_CAPACITY + 1);
  localparam int RCNT_W  = $clog2(RECORD_CAPACITY + 1);
  localparam int TIME_W  = 32;
  localparam int SIZE_W  = 8;
  localparam int REC_W   = TIME_W + BCNT_W;

  localparam logic [BCNT_W-1:0] BYTE_CAP_C = BCNT_W'(BYTE_CAPACITY);
  localparam logic [RCNT_W-1:0] REC_CAP_C  = RCNT_W'(RECORD_CAPACITY);

  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TOO_LARGE = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_REC    = 3'b010,
    S_STREAM = 3'b100
  } state_t;

endpackage

// ----- hw/rtl/timed_message_byte_queue_core.sv -----
// ----------------------------------------------------------------------------
// timed_message_byte_queue_core
// FIFO of timestamped variable-length messages held in a byte ring memory
// and a record ring memory of time and length.
// ----------------------------------------------------------------------------
// Enqueue items are taken one per cycle while busy is low; a message's status
// appears in the cycle after its last byte is accepted, as does an empty dequeue's.
// A dequeue of an N-byte message keeps busy high until its last result is
// issued: the record read state also yields the first byte, then one byte per
// cycle follows. Its first result is registered in the record read state.
// Synchronous reset empties both rings; the memories themselves are not cleared.
module timed_message_byte_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [31:0] event_time,
  input  logic [7:0]  event_size,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        done,
  output logic        kind,
  output logic [1:0]  status,
  output logic [31:0] out_time,
  output logic [6:0]  out_size,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_of_run,
  output logic [6:0]  free_bytes
);

  tmbq_pkg::state_t state;

  logic [tmbq_pkg::BYTE_AW-1:0] byte_head;
  logic [tmbq_pkg::BCNT_W-1:0]  byte_count;
  logic [tmbq_pkg::REC_AW-1:0]  record_head;
  logic [tmbq_pkg::RCNT_W-1:0]  record_count;
  logic                         enqueue_in_progress;
  tmbq_pkg::status_t            enqueue_verdict;
  logic [tmbq_pkg::TIME_W-1:0]  open_time;
  logic [tmbq_pkg::SIZE_W-1:0]  open_size;
  logic [tmbq_pkg::BCNT_W-1:0]  open_stored;
  logic [tmbq_pkg::BYTE_AW-1:0] write_ptr;
  logic [tmbq_pkg::BYTE_AW-1:0] stream_ptr;
  logic [tmbq_pkg::BCNT_W-1:0]  remain;

  logic [7:0]                   byte_mem [tmbq_pkg::BYTE_CAPACITY];
  logic [tmbq_pkg::REC_W-1:0]   rec_mem  [tmbq_pkg::RECORD_CAPACITY];
  logic [7:0]                   byte_q;
  logic [tmbq_pkg::REC_W-1:0]   rec_q;

  logic                         accept;
  logic                         enq_go;
  logic                         deq_go;
  logic                         first;
  tmbq_pkg::status_t            verdict_now;
  tmbq_pkg::status_t            first_verdict;
  logic [tmbq_pkg::SIZE_W-1:0]  size_now;
  logic [tmbq_pkg::BCNT_W-1:0]  stored_now;
  logic [tmbq_pkg::BCNT_W-1:0]  stored_next;
  logic [tmbq_pkg::TIME_W-1:0]  time_now;
  logic [tmbq_pkg::BYTE_AW-1:0] ptr_now;
  logic                         store_byte;
  logic                         commit;
  logic [tmbq_pkg::BCNT_W-1:0]  byte_count_next;
  logic [tmbq_pkg::RCNT_W-1:0]  record_count_next;
  logic [tmbq_pkg::BYTE_AW-1:0] byte_raddr;
  logic [tmbq_pkg::BCNT_W-1:0]  rec_len;
  logic [tmbq_pkg::BCNT_W-1:0]  deq_len;
  logic [tmbq_pkg::BCNT_W-1:0]  byte_left;

  function automatic logic [6:0] free_of(input logic [tmbq_pkg::RCNT_W-1:0] rc,
                                         input logic [tmbq_pkg::BCNT_W-1:0] bc);
    logic [tmbq_pkg::BCNT_W-1:0] room;
    room = tmbq_pkg::BYTE_CAP_C - bc;
    if (rc >= tmbq_pkg::REC_CAP_C) begin
      return 7'd0;
    end
    return 7'(room);
  endfunction

  assign busy   = (state != tmbq_pkg::S_IDLE);
  assign accept = start && !busy;
  assign enq_go = accept && (mode == tmbq_pkg::MODE_ENQ);
  assign deq_go = accept && (mode == tmbq_pkg::MODE_DEQ);
  assign first  = !enqueue_in_progress;

  // The verdict of a message is fixed on its first byte.
  always_comb begin
    if ({1'b0, event_size} > 9'(tmbq_pkg::BYTE_CAPACITY)) begin
      first_verdict = tmbq_pkg::ST_TOO_LARGE;
    end else if (record_count >= tmbq_pkg::REC_CAP_C ||
                 {1'b0, event_size} > 9'(tmbq_pkg::BYTE_CAP_C - byte_count)) begin
      first_verdict = tmbq_pkg::ST_FULL;
    end else begin
      first_verdict = tmbq_pkg::ST_OK;
    end
  end

  always_comb begin
    verdict_now = first ? first_verdict : enqueue_verdict;
    size_now    = first ? event_size : open_size;
    stored_now  = first ? '0 : open_stored;
    time_now    = first ? event_time : open_time;
    ptr_now     = first ? (byte_head + byte_count[tmbq_pkg::BYTE_AW-1:0]) : write_ptr;
    store_byte  = enq_go && (verdict_now == tmbq_pkg::ST_OK) &&
                  ({1'b0, stored_now} < 8'(size_now));
    stored_next = store_byte ? stored_now + 1'b1 : stored_now;
    commit      = enq_go && last_byte && (verdict_now == tmbq_pkg::ST_OK);
  end

  assign byte_count_next   = byte_count + stored_next;
  assign record_count_next = record_count + 1'b1;

  assign rec_len    = rec_q[tmbq_pkg::BCNT_W-1:0];
  assign deq_len    = (rec_len > byte_count) ? byte_count : rec_len;
  assign byte_left  = byte_count - deq_len;
  assign byte_raddr = (state == tmbq_pkg::S_IDLE) ? byte_head : stream_ptr;

  // Byte ring: one write port for enqueue, one registered read port for dequeue.
  always_ff @(posedge clk) begin
    if (store_byte) begin
      byte_mem[ptr_now] <= data_byte;
    end
    byte_q <= byte_mem[byte_raddr];
  end

  // Record ring: the slot after the newest is written on commit.
  always_ff @(posedge clk) begin
    if (commit) begin
      rec_mem[record_head + record_count[tmbq_pkg::REC_AW-1:0]] <=
        {time_now, stored_next};
    end
    rec_q <= rec_mem[record_head];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= tmbq_pkg::S_IDLE;
      byte_head           <= '0;
      byte_count          <= '0;
      record_head         <= '0;
      record_count        <= '0;
      enqueue_in_progress <= 1'b0;
      enqueue_verdict     <= tmbq_pkg::ST_OK;
      done                <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        tmbq_pkg::S_IDLE: begin
          if (enq_go) begin
            enqueue_in_progress <= !last_byte;
            enqueue_verdict     <= verdict_now;
            open_time           <= time_now;
            open_size           <= size_now;
            open_stored         <= stored_next;
            write_ptr           <= store_byte ? ptr_now + 1'b1 : ptr_now;
            if (commit) begin
              byte_count   <= byte_count_next;
              record_count <= record_count_next;
            end
            if (last_byte) begin
              done        <= 1'b1;
              kind        <= tmbq_pkg::KIND_ENQ;
              status      <= verdict_now;
              out_time    <= '0;
              out_size    <= '0;
              out_byte    <= '0;
              byte_valid  <= 1'b0;
              last_of_run <= 1'b1;
              free_bytes  <= commit ? free_of(record_count_next, byte_count_next)
                                    : free_of(record_count, byte_count);
            end
          end else if (deq_go) begin
            if (record_count == '0) begin
              done        <= 1'b1;
              kind        <= tmbq_pkg::KIND_DEQ;
              status      <= tmbq_pkg::ST_EMPTY;
              out_time    <= '0;
              out_size    <= '0;
              out_byte    <= '0;
              byte_valid  <= 1'b0;
              last_of_run <= 1'b1;
              free_bytes  <= free_of(record_count, byte_count);
            end else begin
              stream_ptr <= byte_head + 1'b1;
              state      <= tmbq_pkg::S_REC;
            end
          end
        end
        tmbq_pkg::S_REC: begin
          // Record data and the first byte are both ready in this cycle.
          record_head  <= record_head + 1'b1;
          record_count <= record_count - 1'b1;
          byte_head    <= byte_head + deq_len[tmbq_pkg::BYTE_AW-1:0];
          byte_count   <= byte_left;
          stream_ptr   <= stream_ptr + 1'b1;
          remain       <= deq_len - 1'b1;
          done         <= 1'b1;
          kind         <= tmbq_pkg::KIND_DEQ;
          status       <= tmbq_pkg::ST_OK;
          out_time     <= rec_q[tmbq_pkg::REC_W-1:tmbq_pkg::BCNT_W];
          out_size     <= 7'(deq_len);
          free_bytes   <= 7'(tmbq_pkg::BYTE_CAP_C - byte_left);
          if (deq_len == '0) begin
            out_byte    <= '0;
            byte_valid  <= 1'b0;
            last_of_run <= 1'b1;
            state       <= tmbq_pkg::S_IDLE;
          end else begin
            out_byte    <= byte_q;
            byte_valid  <= 1'b1;
            last_of_run <= (deq_len == tmbq_pkg::BCNT_W'(1));
            state       <= (deq_len == tmbq_pkg::BCNT_W'(1)) ? tmbq_pkg::S_IDLE
                                                             : tmbq_pkg::S_STREAM;
          end
        end
        tmbq_pkg::S_STREAM: begin
          stream_ptr  <= stream_ptr + 1'b1;
          remain      <= remain - 1'b1;
          done        <= 1'b1;
          out_byte    <= byte_q;
          last_of_run <= (remain == tmbq_pkg::BCNT_W'(1));
          if (remain == tmbq_pkg::BCNT_W'(1)) begin
            state <= tmbq_pkg::S_IDLE;
          end
        end
        default: begin
          state <= tmbq_pkg::S_IDLE;
        end
      endcase
    end
  end

  a_stream_emits: assert property (@(posedge clk) disable iff (rst)
    (state == tmbq_pkg::S_STREAM) |=> done)
    else $error("byte stream cycle produced no result");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (byte_count <= tmbq_pkg::BYTE_CAP_C) && (record_count <= tmbq_pkg::REC_CAP_C))
    else $error("ring occupancy beyond capacity");

  a_mid_run_is_byte: assert property (@(posedge clk) disable iff (rst)
    (done && !last_of_run) |-> (kind == tmbq_pkg::KIND_DEQ) && byte_valid)
    else $error("non-final result is not a dequeued byte");

  a_deq_reads_record: assert property (@(posedge clk) disable iff (rst)
    (deq_go && (record_count != '0)) |=> (state == tmbq_pkg::S_REC))
    else $error("dequeue of a held message did not read its record");

endmodule
